### design/assert_macros.svh
// Assertion macros used by linear_probe_hash_table.sv.
// Depends on nothing; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### design/lpht_pkg.sv
// Package for the linear probe hash table: opcodes, status codes, states.
// Depends on nothing.
`default_nettype none
package lpht_pkg;
   localparam int MAX_SLOTS = 256;
   typedef enum logic [2:0] {
      OP_KEY_BYTE = 3'd0,
      OP_INSERT   = 3'd1,
      OP_SEARCH_S = 3'd2,
      OP_SEARCH_N = 3'd3,
      OP_NEXT_OCC = 3'd4
   } op_type;
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2,
      ST_DUP  = 2'd3
   } status_type;
   typedef enum logic [2:0] {
      S_IDLE, S_MOD, S_PROBE, S_CHECK, S_DONE
   } state_type;
   localparam logic [63:0] HASH_SEED  = 64'd5381;
   localparam int          HASH_SHIFT = 5;
endpackage
`default_nettype wire

### design/lpht_chan_if.sv
// Valid/ready channel interface carrying one item of a given payload type.
// Depends on nothing.
`default_nettype none
interface lpht_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/lpht_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

### design/linear_probe_hash_table.sv
// Linear probe hash table: open addressing over a key/value RAM.
// Uses lpht_pkg, lpht_chan_if, lpht_ram and assert_macros.svh.
//
// Channels: req (op, key_byte, search_key, value, start_index) in, rsp
// (status, value_out, found_key, found_index) out, both valid/ready; the
// csr port writes table_size (0 acts as 1, above MAX_SLOTS as MAX_SLOTS).
// A key byte folds into the djb2 hash and gives no item.
// Insert and searches first reduce the 64-bit key modulo the size with a
// restoring divider, one quotient bit a cycle, then walk the probe
// sequence through the slot RAM, each occupied slot passing through
// S_PROBE (address) and then S_CHECK (registered read and compare).
// Next-occupied walks from start_index the same way. One item is in work
// at a time; req_ready is low until its result has left the output
// register. Reset sets the hash to HASH_SEED and clears the count and all
// slot valid bits (flip-flops) at once. A stalled receiver holds the
// result; nothing is dropped.
`default_nettype none
`include "assert_macros.svh"
module linear_probe_hash_table #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   lpht_chan_if.sink   req,
   lpht_chan_if.source rsp,
   input  wire logic       csr_we,
   input  wire logic [8:0] csr_wdata
);
   localparam int AW = $clog2(lpht_pkg::MAX_SLOTS);
   localparam int SW = AW + 1;

   // Request payload members: op, key_byte, search_key, value, start_index.
   // Response payload members: status, value_out, found_key, found_index.

   lpht_pkg::state_type state_ff, state_in;
   logic [63:0]  hash_ff, hash_in;
   logic [8:0]   size_ff;
   logic [2:0]   op_ff, op_in;
   logic [63:0]  key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [6:0]   bit_ff, bit_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] items_ff, items_in;
   logic [lpht_pkg::MAX_SLOTS-1:0] valid_ff, valid_in;
   logic         rv_ff, rv_in;
   logic [1:0]   st_ff, st_in;
   logic [31:0]  vo_ff, vo_in;
   logic [63:0]  fk_ff, fk_in;
   logic [8:0]   fi_ff, fi_in;

   logic [SW-1:0] n;
   logic [SW:0]   trial;
   logic          wr_en;
   logic [63:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   logic [AW-1:0] addr;
   logic          slot_v;
   logic [SW-1:0] idx_nx;

   always_comb begin
      if (size_ff == 9'd0) begin
         n = SW'(1);
      end else if ({23'd0, size_ff} > lpht_pkg::MAX_SLOTS) begin
         n = SW'(lpht_pkg::MAX_SLOTS);
      end else begin
         n = SW'(size_ff);
      end
   end

   assign addr   = idx_ff[AW-1:0];
   assign slot_v = valid_ff[addr];
   assign idx_nx = (idx_ff + SW'(1) >= n) ? SW'(0) : idx_ff + SW'(1);
   assign trial  = {rem_ff, key_ff[6'(bit_ff - 7'd1)]};

   lpht_ram #(.WIDTH(64), .DEPTH(lpht_pkg::MAX_SLOTS)) u_keys (
      .clock(clock), .wr_en(wr_en), .addr(addr), .wr_data(key_ff), .rd_data(rd_key));
   lpht_ram #(.WIDTH(VALUE_BITS), .DEPTH(lpht_pkg::MAX_SLOTS)) u_vals (
      .clock(clock), .wr_en(wr_en), .addr(addr), .wr_data(val_ff), .rd_data(rd_val));

   assign req.ready = (state_ff == lpht_pkg::S_IDLE) && !rv_ff;
   assign rsp.valid = rv_ff;
   assign rsp.data.status      = st_ff;
   assign rsp.data.value_out   = vo_ff;
   assign rsp.data.found_key   = fk_ff;
   assign rsp.data.found_index = fi_ff;

   always_comb begin
      state_in = state_ff; hash_in = hash_ff; op_in = op_ff; key_in = key_ff;
      val_in = val_ff; rem_in = rem_ff; bit_in = bit_ff; idx_in = idx_ff;
      cnt_in = cnt_ff; items_in = items_ff; valid_in = valid_ff;
      rv_in = rv_ff && !rsp.ready; st_in = st_ff; vo_in = vo_ff;
      fk_in = fk_ff; fi_in = fi_ff; wr_en = 1'b0;
      case (state_ff)
         lpht_pkg::S_IDLE: begin
            if (req.valid && req.ready) begin
               op_in  = req.data.op;
               val_in = VALUE_BITS'(req.data.value);
               rem_in = '0;
               bit_in = 7'd64;
               cnt_in = '0;
               st_in = lpht_pkg::ST_MISS; vo_in = '0; fk_in = '0; fi_in = '0;
               case (lpht_pkg::op_type'(req.data.op))
                  lpht_pkg::OP_KEY_BYTE: begin
                     hash_in = (hash_ff << lpht_pkg::HASH_SHIFT) + hash_ff
                               + {56'd0, req.data.key_byte};
                  end
                  lpht_pkg::OP_INSERT, lpht_pkg::OP_SEARCH_S: begin
                     key_in = hash_ff;
                     hash_in = lpht_pkg::HASH_SEED;
                     if (req.data.op == lpht_pkg::OP_INSERT && items_ff >= n) begin
                        st_in = lpht_pkg::ST_FULL;
                        state_in = lpht_pkg::S_DONE;
                     end else begin
                        state_in = lpht_pkg::S_MOD;
                     end
                  end
                  lpht_pkg::OP_SEARCH_N: begin
                     key_in = req.data.search_key;
                     state_in = lpht_pkg::S_MOD;
                  end
                  lpht_pkg::OP_NEXT_OCC: begin
                     fi_in = 9'(n);
                     if ({7'd0, req.data.start_index} >= 16'(n)) begin
                        state_in = lpht_pkg::S_DONE;
                     end else begin
                        idx_in = SW'(req.data.start_index);
                        state_in = lpht_pkg::S_PROBE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         lpht_pkg::S_MOD: begin
            // restoring division: one key bit per cycle
            if (trial >= {1'b0, n}) begin
               rem_in = SW'(trial - {1'b0, n});
            end else begin
               rem_in = SW'(trial);
            end
            bit_in = bit_ff - 7'd1;
            if (bit_ff == 7'd1) begin
               idx_in = (trial >= {1'b0, n}) ? SW'(trial - {1'b0, n}) : SW'(trial);
               state_in = lpht_pkg::S_PROBE;
            end
         end
         lpht_pkg::S_PROBE: begin
            // RAM read of slot idx is in flight; insert into empty slot now
            if (op_ff == lpht_pkg::OP_INSERT && !slot_v) begin
               wr_en = 1'b1;
               valid_in[addr] = 1'b1;
               items_in = items_ff + SW'(1);
               st_in = lpht_pkg::ST_OK;
               state_in = lpht_pkg::S_DONE;
            end else if (op_ff == lpht_pkg::OP_NEXT_OCC && slot_v) begin
               state_in = lpht_pkg::S_CHECK;
            end else if (op_ff == lpht_pkg::OP_NEXT_OCC) begin
               if (idx_ff + SW'(1) >= n) begin
                  state_in = lpht_pkg::S_DONE;
               end else begin
                  idx_in = idx_ff + SW'(1);
               end
            end else if (!slot_v) begin
               // search skips empty slots
               cnt_in = cnt_ff + SW'(1);
               idx_in = idx_nx;
               if (cnt_ff + SW'(1) >= n) state_in = lpht_pkg::S_DONE;
            end else begin
               state_in = lpht_pkg::S_CHECK;
            end
         end
         lpht_pkg::S_CHECK: begin
            if (op_ff == lpht_pkg::OP_NEXT_OCC) begin
               st_in = lpht_pkg::ST_OK;
               fk_in = rd_key;
               fi_in = 9'(idx_ff);
               state_in = lpht_pkg::S_DONE;
            end else if (rd_key == key_ff) begin
               if (op_ff == lpht_pkg::OP_INSERT) begin
                  st_in = lpht_pkg::ST_DUP;
               end else begin
                  st_in = lpht_pkg::ST_OK;
                  vo_in = 32'(rd_val);
               end
               state_in = lpht_pkg::S_DONE;
            end else begin
               cnt_in = cnt_ff + SW'(1);
               idx_in = idx_nx;
               if (cnt_ff + SW'(1) >= n) begin
                  if (op_ff == lpht_pkg::OP_INSERT) st_in = lpht_pkg::ST_FULL;
                  state_in = lpht_pkg::S_DONE;
               end else begin
                  state_in = lpht_pkg::S_PROBE;
               end
            end
         end
         lpht_pkg::S_DONE: begin
            rv_in = 1'b1;
            state_in = lpht_pkg::S_IDLE;
         end
         default: state_in = lpht_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpht_pkg::S_IDLE;
         hash_ff  <= lpht_pkg::HASH_SEED;
         size_ff  <= 9'(lpht_pkg::MAX_SLOTS);
         items_ff <= '0;
         valid_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
         items_ff <= items_in;
         valid_ff <= valid_in;
         rv_ff    <= rv_in;
         if (csr_we) size_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; key_ff <= key_in; val_ff <= val_in; rem_ff <= rem_in;
      bit_ff <= bit_in; idx_ff <= idx_in; cnt_ff <= cnt_in;
      st_ff <= st_in; vo_ff <= vo_in; fk_ff <= fk_in; fi_ff <= fi_in;
   end

   `ASSERT_CLK(a_count_bits, clock, reset, items_ff == SW'($countones(valid_ff)), "count mismatch")
   `ASSERT_CLK(a_hold_rsp, clock, reset, rv_ff && !rsp.ready |=> rv_ff && $stable(st_ff), "result dropped")
   `ASSERT_CLK(a_one_item, clock, reset, rv_ff |-> state_ff == lpht_pkg::S_IDLE, "overlap")
endmodule
`default_nettype wire
